// ===== sv/ps2mct_pkg.sv =====
// Package for the PS/2 mouse cursor tracker: payload structs, divider handshake
// structs, register indexes and reset constants. No dependencies.
package ps2mct_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 13;
    localparam int RES_W   = 14;
    localparam int BTN_W   = 3;
    localparam int MAG_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    // Reset values.
    localparam logic [BYTE_W-1:0] SENS_RESET   = 8'd2;
    localparam logic [RES_W-1:0]  WIDTH_RESET  = 14'd800;
    localparam logic [RES_W-1:0]  HEIGHT_RESET = 14'd600;
    localparam logic [POS_W-1:0]  POS_X_RESET  = 13'd400;
    localparam logic [POS_W-1:0]  POS_Y_RESET  = 13'd300;
    localparam logic [RES_W-1:0]  MAX_RES      = 14'd8192;

    // Status and header bit positions.
    localparam int STAT_DATA_READY = 0;
    localparam int STAT_AUX_DATA   = 5;
    localparam int HDR_X_SIGN      = 4;
    localparam int HDR_Y_SIGN      = 5;

    typedef struct packed {
        logic [BYTE_W-1:0] port_status;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic [BTN_W-1:0] button_bits;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  dividend;
        logic [BYTE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/ps2mct_div.sv =====
// Bit-serial restoring divider for delta magnitudes, one quotient bit a cycle.
// Depends on ps2mct_pkg.
module ps2mct_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ps2mct_pkg::t_div_req i_req,
    output ps2mct_pkg::t_div_rsp o_rsp
);
    import ps2mct_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_rem;
    logic [MAG_W-1:0]  r_quo;
    logic [BYTE_W-1:0] r_div;

    logic [BYTE_W:0]   trial;
    logic              fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[MAG_W-1]};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= BYTE_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[BYTE_W-1:0];
            end
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/ps2mct_top.sv =====
// Divider activity monitor: flags when the shared divider has no division in progress.
// Depends on ps2mct_pkg.
module ps2mct_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ps2mct_pkg::t_div_rsp i_rsp,
    input  logic                 i_busy,
    output logic                 o_idle_seen
);
    import ps2mct_pkg::*;

    // Set when a division completes, cleared when a new one starts.
    logic r_idle_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_seen <= 1'b1;
        end else if (i_rsp.done) begin
            r_idle_seen <= 1'b1;
        end else if (i_busy) begin
            r_idle_seen <= 1'b0;
        end
    end

    assign o_idle_seen = r_idle_seen;

endmodule

// ===== sv/ps2_mouse_cursor_tracker.sv =====
// PS/2 mouse cursor tracker top level; depends on ps2mct_pkg, ps2mct_div and ps2mct_top.
// A byte that does not complete a packet is taken while the sequencer is idle. The third
// byte of a packet stalls the input after its transfer while, for X and then Y, a start
// state, nine divider steps and a hand-off run, then an update state that registers the
// result. Only one packet end is worked on at a time. Reset (i_rst_n
// low, synchronous) restores sensitivity 2, 800x600, cursor (400, 300), no buttons, byte 0.
module ps2_mouse_cursor_tracker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input byte channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  ps2mct_pkg::t_in_item                 i_in_item,
    // Cursor result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output ps2mct_pkg::t_out_item                o_out_item,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ps2mct_pkg::RES_W-1:0]         i_cfg_data
);
    import ps2mct_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STARTX = 3'd1;
    localparam logic [2:0] ST_WAITX  = 3'd2;
    localparam logic [2:0] ST_STARTY = 3'd3;
    localparam logic [2:0] ST_WAITY  = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;

    // Packet byte positions.
    localparam logic [1:0] BYTE_HEADER = 2'd0;
    localparam logic [1:0] BYTE_XDELTA = 2'd1;
    localparam logic [1:0] BYTE_YDELTA = 2'd2;

    localparam int SUM_W = POS_W + 2;

    // Configuration registers.
    logic [BYTE_W-1:0] r_sensitivity;
    logic [RES_W-1:0]  r_screen_width;
    logic [RES_W-1:0]  r_screen_height;

    // Packet and cursor state.
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [1:0]        r_byte_index;
    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_x_byte;
    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;
    logic [BTN_W-1:0]  r_buttons;

    // Working registers for the packet end being processed.
    logic              r_neg_x;
    logic              r_neg_y;
    logic [MAG_W-1:0]  r_mag_x;
    logic [MAG_W-1:0]  r_mag_y;
    logic [MAG_W-1:0]  r_quo_x;

    // Result register.
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              offered;
    logic              completes;
    logic              in_xfer;
    logic              out_xfer;
    logic              cfg_xfer;
    logic [MAG_W-1:0]  raw_x;
    logic [MAG_W-1:0]  raw_y;
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic              div_idle;

    logic signed [SUM_W-1:0] step_x;
    logic signed [SUM_W-1:0] step_y;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [POS_W-1:0]        top_x;
    logic [POS_W-1:0]        top_y;
    logic [POS_W-1:0]        new_x;
    logic [POS_W-1:0]        new_y;

    // A byte counts only when the controller flags it ready and from the mouse.
    assign offered   = i_in_item.port_status[STAT_DATA_READY]
                     & i_in_item.port_status[STAT_AUX_DATA];
    // Byte positions at or past the third are treated as the last byte.
    assign completes = offered && (r_byte_index != BYTE_HEADER)
                     && (r_byte_index != BYTE_XDELTA);

    // Stall while the divider sequence runs. A packet end also waits for the
    // result register to empty, while other bytes keep flowing.
    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && completes)
                       || !div_idle;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // Sign-extend the deltas to 9 bits and take their magnitudes; -256 maps to 256.
    assign raw_x = {r_header[HDR_X_SIGN], r_x_byte};
    assign raw_y = {r_header[HDR_Y_SIGN], i_in_item.data_byte};

    // Configuration writes. A sensitivity of zero is stored as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensitivity   <= SENS_RESET;
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_SENSITIVITY: begin
                    if (i_cfg_data[BYTE_W-1:0] == '0) begin
                        r_sensitivity <= BYTE_W'(1);
                    end else begin
                        r_sensitivity <= i_cfg_data[BYTE_W-1:0];
                    end
                end
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The shared divider is used twice per packet end: first X, then Y.
    always_comb begin
        div_req.start    = (r_state == ST_STARTX) || (r_state == ST_STARTY);
        div_req.dividend = (r_state == ST_STARTY) ? r_mag_y : r_mag_x;
        div_req.divisor  = r_sensitivity;
    end

    ps2mct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ps2mct_top u_mon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rsp       (div_rsp),
        .i_busy      (div_req.start),
        .o_idle_seen (div_idle)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_xfer && completes) n_state = ST_STARTX;
            ST_STARTX: n_state = ST_WAITX;
            ST_WAITX:  if (div_rsp.done) n_state = ST_STARTY;
            ST_STARTY: n_state = ST_WAITY;
            ST_WAITY:  if (div_rsp.done) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Top of each axis: resolution minus one, with zero acting as one and
    // anything above the maximum acting as the maximum.
    always_comb begin
        if (r_screen_width == '0) begin
            top_x = '0;
        end else if (r_screen_width > MAX_RES) begin
            top_x = POS_W'(MAX_RES - 1'b1);
        end else begin
            top_x = POS_W'(r_screen_width - 1'b1);
        end
        if (r_screen_height == '0) begin
            top_y = '0;
        end else if (r_screen_height > MAX_RES) begin
            top_y = POS_W'(MAX_RES - 1'b1);
        end else begin
            top_y = POS_W'(r_screen_height - 1'b1);
        end
    end

    // Quotients are truncated toward zero because the sign is applied after the
    // magnitude division. X moves right on positive, Y moves down on negative.
    always_comb begin
        step_x = $signed({{(SUM_W-MAG_W){1'b0}}, r_quo_x});
        step_y = $signed({{(SUM_W-MAG_W){1'b0}}, div_rsp.quotient});
        if (r_neg_x) begin
            step_x = -step_x;
        end
        if (r_neg_y) begin
            step_y = -step_y;
        end
        sum_x = $signed({2'b00, r_pos_x}) + step_x;
        sum_y = $signed({2'b00, r_pos_y}) - step_y;

        priority if (sum_x < 0) begin
            new_x = '0;
        end else if (sum_x > $signed({2'b00, top_x})) begin
            new_x = top_x;
        end else begin
            new_x = sum_x[POS_W-1:0];
        end

        priority if (sum_y < 0) begin
            new_y = '0;
        end else if (sum_y > $signed({2'b00, top_y})) begin
            new_y = top_y;
        end else begin
            new_y = sum_y[POS_W-1:0];
        end
    end

    // Control state: sequencer, packet alignment, cursor, buttons, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_byte_index <= BYTE_HEADER;
            r_header     <= '0;
            r_x_byte     <= '0;
            r_pos_x      <= POS_X_RESET;
            r_pos_y      <= POS_Y_RESET;
            r_buttons    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer && offered) begin
                priority if (r_byte_index == BYTE_HEADER) begin
                    r_header     <= i_in_item.data_byte;
                    r_byte_index <= BYTE_XDELTA;
                end else if (r_byte_index == BYTE_XDELTA) begin
                    r_x_byte     <= i_in_item.data_byte;
                    r_byte_index <= BYTE_YDELTA;
                end else begin
                    r_byte_index <= BYTE_HEADER;
                    r_buttons    <= r_header[BTN_W-1:0];
                end
            end
            if (r_state == ST_UPDATE) begin
                r_pos_x     <= new_x;
                r_pos_y     <= new_y;
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer && completes) begin
            r_neg_x <= raw_x[MAG_W-1];
            r_neg_y <= raw_y[MAG_W-1];
            r_mag_x <= raw_x[MAG_W-1] ? MAG_W'(~raw_x + 1'b1) : raw_x;
            r_mag_y <= raw_y[MAG_W-1] ? MAG_W'(~raw_y + 1'b1) : raw_y;
        end
        if ((r_state == ST_WAITX) && div_rsp.done) begin
            r_quo_x <= div_rsp.quotient;
        end
        if (r_state == ST_UPDATE) begin
            r_out_item.cursor_x    <= new_x;
            r_out_item.cursor_y    <= new_y;
            r_out_item.button_bits <= r_buttons;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
